@@ rtl/ewq_pkg.sv @@
// types and constants shared by the eeprom write queue unit
`default_nettype none

package ewq_pkg;

    localparam int CMD_W  = 2;
    localparam int ADDR_W = 10;
    localparam int DATA_W = 8;
    localparam int ST_W   = 2;

    localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_READY = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_code_t;

    typedef enum logic [ST_W-1:0] {
        ST_ACCEPTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_IDLE     = 2'd2,
        ST_READ     = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    enqueue;
        logic    q_read;
        logic    pop;
        logic    cell_read_q;
        logic    cell_read_in;
        logic    cell_write;
        logic    clear_write;
        logic    busy_clear;
        logic    load_result;
        status_t res_status;
        logic    res_use_rd;
        logic    res_written;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        cmd_code_t cmd;
        logic      q_full;
        logic      q_empty;
        logic      skip_equal;
        logic      clear_last;
        logic      out_free;
    } ctl_sts_t;

endpackage

`default_nettype wire

@@ rtl/ewq_intf.sv @@
// item, result and configuration channel interfaces
`default_nettype none

interface ewq_item_if;
    import ewq_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;

    modport source (output valid, output cmd, output address, output data, input ready);
    modport sink (input valid, input cmd, input address, input data, output ready);
endinterface

interface ewq_result_if #(
    parameter int CNT_W = 6
);
    import ewq_pkg::*;

    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] read_data;
    logic              cell_written;
    logic              busy_res;
    logic [CNT_W-1:0]  queue_count;

    modport source (
        output valid, output status, output read_data, output cell_written,
        output busy_res, output queue_count, input ready
    );
    modport sink (
        input valid, input status, input read_data, input cell_written,
        input busy_res, input queue_count, output ready
    );
endinterface

interface ewq_cfg_if;
    logic valid;
    logic ready;
    logic skip_unchanged;

    modport source (output valid, output skip_unchanged, input ready);
    modport sink (input valid, input skip_unchanged, output ready);
endinterface

`default_nettype wire

@@ rtl/ewq_ctrl.sv @@
// sequencing state machine of the eeprom write queue unit
`default_nettype none

module ewq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ewq_pkg::ctl_sts_t sts,
    output ewq_pkg::ctl_cmd_t      cmd
);
    import ewq_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_DECODE = 7'b0000100,
        S_QRD    = 7'b0001000,
        S_CMP    = 7'b0010000,
        S_CELLRD = 7'b0100000,
        S_RDDONE = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = sts.out_free;
                if (in_valid && sts.out_free)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.cmd)
                    CMD_WRITE:
                    begin
                        cmd.load_result = 1'b1;
                        state_next      = S_IDLE;
                        if (sts.q_full)
                        begin
                            cmd.res_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.enqueue    = 1'b1;
                            cmd.res_status = ST_ACCEPTED;
                        end
                    end
                    CMD_READY:
                    begin
                        if (sts.q_empty)
                        begin
                            cmd.busy_clear  = 1'b1;
                            cmd.load_result = 1'b1;
                            cmd.res_status  = ST_IDLE;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            cmd.q_read = 1'b1;
                            state_next = S_QRD;
                        end
                    end
                    CMD_READ:
                    begin
                        if (sts.q_empty)
                        begin
                            cmd.busy_clear = 1'b1;
                            state_next     = S_CELLRD;
                        end
                        else
                        begin
                            cmd.q_read = 1'b1;
                            state_next = S_QRD;
                        end
                    end
                    default:
                    begin
                        cmd.load_result = 1'b1;
                        cmd.res_status  = ST_ACCEPTED;
                        state_next      = S_IDLE;
                    end
                endcase
            end
            S_QRD:
            begin
                cmd.cell_read_q = 1'b1;
                cmd.pop         = 1'b1;
                state_next      = S_CMP;
            end
            S_CMP:
            begin
                cmd.cell_write = !sts.skip_equal;
                if (sts.cmd == CMD_READY)
                begin
                    cmd.load_result = 1'b1;
                    cmd.res_status  = ST_ACCEPTED;
                    cmd.res_written = !sts.skip_equal;
                    state_next      = S_IDLE;
                end
                else if (sts.q_empty)
                begin
                    cmd.busy_clear = 1'b1;
                    state_next     = S_CELLRD;
                end
                else
                begin
                    cmd.q_read = 1'b1;
                    state_next = S_QRD;
                end
            end
            S_CELLRD:
            begin
                cmd.cell_read_in = 1'b1;
                state_next       = S_RDDONE;
            end
            S_RDDONE:
            begin
                cmd.load_result = 1'b1;
                cmd.res_status  = ST_READ;
                cmd.res_use_rd  = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/ewq_datapath.sv @@
// queue memory, cell store and result register of the eeprom write queue unit
`default_nettype none

module ewq_datapath #(
    parameter int QUEUE_DEPTH = 32,
    parameter int STORE_BYTES = 1024,
    parameter int CNT_W       = 6
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ewq_pkg::ctl_cmd_t          cmd,
    output ewq_pkg::ctl_sts_t               sts,
    input  wire logic [ewq_pkg::CMD_W-1:0]  item_cmd,
    input  wire logic [ewq_pkg::ADDR_W-1:0] item_address,
    input  wire logic [ewq_pkg::DATA_W-1:0] item_data,
    input  wire logic                       cfg_write,
    input  wire logic                       cfg_skip,
    output logic                            res_valid,
    input  wire logic                       res_ready,
    output logic [ewq_pkg::ST_W-1:0]        res_status,
    output logic [ewq_pkg::DATA_W-1:0]      res_read_data,
    output logic                            res_cell_written,
    output logic                            res_busy,
    output logic [CNT_W-1:0]                res_count
);
    import ewq_pkg::*;

    localparam int QW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW        = $clog2(STORE_BYTES);
    localparam int QMAX      = ((1 << ADDR_W) - 1) / STORE_BYTES;
    localparam int RED_STEPS = (QMAX > 0) ? $clog2(QMAX + 1) : 1;

    // address modulo store size, by restoring subtraction
    function automatic logic [CW-1:0] cell_of(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        r = a;
        for (int k = RED_STEPS - 1; k >= 0; k--)
        begin
            if (32'(r) >= (32'(STORE_BYTES) << k))
            begin
                r = r - ADDR_W'(32'(STORE_BYTES) << k);
            end
        end
        return CW'(r);
    endfunction

    logic [ADDR_W-1:0] q_addr_mem [QUEUE_DEPTH];
    logic [DATA_W-1:0] q_byte_mem [QUEUE_DEPTH];
    logic [DATA_W-1:0] cell_mem   [STORE_BYTES];

    cmd_code_t         cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] data_reg;
    logic [ADDR_W-1:0] q_addr_rd_reg;
    logic [DATA_W-1:0] q_byte_rd_reg;
    logic [DATA_W-1:0] cell_rd_reg;

    logic [QW-1:0]     head_reg;
    logic [QW-1:0]     head_next;
    logic [QW-1:0]     tail_reg;
    logic [QW-1:0]     tail_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              busy_reg;
    logic              busy_next;
    logic              skip_reg;
    logic [CW-1:0]     sweep_reg;
    logic              out_valid_reg;

    logic [CW-1:0]     q_cell;
    logic [CW-1:0]     in_cell;

    assign q_cell  = cell_of(q_addr_rd_reg);
    assign in_cell = cell_of(addr_reg);

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        if (cmd.enqueue)
        begin
            tail_next  = (tail_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
            busy_next  = 1'b1;
        end
        if (cmd.pop)
        begin
            head_next  = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        if (cmd.busy_clear)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            skip_reg      <= 1'b0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            busy_reg  <= busy_next;
            if (cfg_write)
            begin
                skip_reg <= cfg_skip;
            end
            if (cmd.clear_write)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item capture, result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg  <= cmd_code_t'(item_cmd);
            addr_reg <= item_address;
            data_reg <= item_data;
        end
        if (cmd.load_result)
        begin
            res_status       <= cmd.res_status;
            res_read_data    <= cmd.res_use_rd ? cell_rd_reg : '0;
            res_cell_written <= cmd.res_written;
            res_busy         <= busy_next;
            res_count        <= count_next;
        end
    end

    // pending pair queue
    always_ff @(posedge clk)
    begin
        if (cmd.enqueue)
        begin
            q_addr_mem[tail_reg] <= addr_reg;
            q_byte_mem[tail_reg] <= data_reg;
        end
        if (cmd.q_read)
        begin
            q_addr_rd_reg <= q_addr_mem[head_reg];
            q_byte_rd_reg <= q_byte_mem[head_reg];
        end
    end

    // cell store
    always_ff @(posedge clk)
    begin
        if (cmd.clear_write)
        begin
            cell_mem[sweep_reg] <= ERASED_BYTE;
        end
        else if (cmd.cell_write)
        begin
            cell_mem[q_cell] <= q_byte_rd_reg;
        end
        if (cmd.cell_read_q)
        begin
            cell_rd_reg <= cell_mem[q_cell];
        end
        else if (cmd.cell_read_in)
        begin
            cell_rd_reg <= cell_mem[in_cell];
        end
    end

    assign sts.cmd        = cmd_reg;
    assign sts.q_full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign sts.q_empty    = (count_reg == '0);
    assign sts.skip_equal = skip_reg && (cell_rd_reg == q_byte_rd_reg);
    assign sts.clear_last = (sweep_reg == CW'(STORE_BYTES - 1));
    assign sts.out_free   = !out_valid_reg;

    assign res_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ rtl/eeprom_write_queue_unit.sv @@
// top level of the eeprom write queue unit
//
//  channel     dir  handshake     payload
//  item_in     in   valid/ready   cmd, address, data
//  result_out  out  valid/ready   status, read_data, cell_written, busy_res, queue_count
//  cfg         in   valid/ready   skip_unchanged
//
//  write and undefined items are answered directly from decode; a ready item on a non-empty queue drains one pair
//  read items drain every queued pair, each pair a queue read then a cell read-write, then read the cell
//  after reset the cell store is swept to erased, with item_in not ready
//  one item at a time; the next item is taken once the last result has left the output register
`default_nettype none

module eeprom_write_queue_unit #(
    parameter int QUEUE_DEPTH = 32,
    parameter int STORE_BYTES = 1024
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ewq_item_if.sink      item_in,
    ewq_result_if.source  result_out,
    ewq_cfg_if.sink       cfg
);
    import ewq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ctl_cmd_t ctl_cmd;
    ctl_sts_t ctl_sts;

    assign cfg.ready = 1'b1;

    ewq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_in.valid),
        .in_ready (item_in.ready),
        .sts      (ctl_sts),
        .cmd      (ctl_cmd)
    );

    ewq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .STORE_BYTES (STORE_BYTES),
        .CNT_W       (CNT_W)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (ctl_cmd),
        .sts              (ctl_sts),
        .item_cmd         (item_in.cmd),
        .item_address     (item_in.address),
        .item_data        (item_in.data),
        .cfg_write        (cfg.valid),
        .cfg_skip         (cfg.skip_unchanged),
        .res_valid        (result_out.valid),
        .res_ready        (result_out.ready),
        .res_status       (result_out.status),
        .res_read_data    (result_out.read_data),
        .res_cell_written (result_out.cell_written),
        .res_busy         (result_out.busy_res),
        .res_count        (result_out.queue_count)
    );

endmodule

`default_nettype wire
